### src/iee_pkg.sv
package iee_pkg;

	localparam int DATA_W   = 64;
	localparam int FIFO_D   = 4;
	localparam int WT_DEPTH = 24;

	// Character classes seen by the back end
	typedef enum logic [2:0] {
		K_DIGIT = 3'd0,
		K_POINT = 3'd1,
		K_PLUS  = 3'd2,
		K_MINUS = 3'd3,
		K_TIMES = 3'd4,
		K_DIV   = 3'd5,
		K_OTHER = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		OP_PLUS  = 3'd0,
		OP_MINUS = 3'd1,
		OP_TIMES = 3'd2,
		OP_DIV   = 3'd3,
		OP_NONE  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DIV0  = 2'd1,
		ST_OVF   = 2'd2,
		ST_NOTRM = 2'd3
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              ovf;
	} sat_t;

	typedef logic [WT_DEPTH-1:0][DATA_W-1:0] wtab_t;

	// ASCII codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TIMES = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;

	// Clamp a magnitude to the signed range and apply the sign
	function automatic sat_t pack_mag(input logic neg, input logic [DATA_W-1:0] mag,
			input logic ovf, input logic [DATA_W-1:0] vmax);
		logic [DATA_W-1:0] lim;
		logic [DATA_W-1:0] m;
		sat_t              r;
		lim   = vmax + {{(DATA_W-1){1'b0}}, neg};
		m     = mag;
		r.ovf = 1'b0;
		if (ovf || mag > lim) begin
			m     = lim;
			r.ovf = 1'b1;
		end
		r.val = neg ? (~m + 1'b1) : m;
		return r;
	endfunction

	// Saturating signed add
	function automatic sat_t sat_add(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input logic [DATA_W-1:0] vmax);
		logic signed [DATA_W:0] s;
		logic signed [DATA_W:0] hi;
		logic signed [DATA_W:0] lo;
		sat_t                   r;
		s     = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
		hi    = $signed({1'b0, vmax});
		lo    = -hi - 1;
		r.ovf = 1'b0;
		r.val = s[DATA_W-1:0];
		if (s > hi) begin
			r.val = hi[DATA_W-1:0];
			r.ovf = 1'b1;
		end else if (s < lo) begin
			r.val = lo[DATA_W-1:0];
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	// Fraction digit weights, evaluated at elaboration
	function automatic wtab_t weight_table(input int frac_bits);
		logic [DATA_W-1:0] w;
		wtab_t             t;
		w = ((64'd1 << frac_bits) + 64'd5) / 64'd10;
		for (int k = 0; k < WT_DEPTH; k++) begin
			t[k] = w;
			w    = (w + 64'd5) / 64'd10;
		end
		return t;
	endfunction

endpackage

### src/iee_front.sv
module iee_front
	import iee_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       tok_valid,
	output tok_t       tok,
	input  logic       tok_pop
);

	localparam int PW = $clog2(FIFO_D);

	tok_t          mem_q [FIFO_D];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	tok_t          cls;
	logic          push;

	// Classify the incoming character
	always_comb begin
		cls.digit = in_char[3:0];
		cls.last  = in_last;
		if (in_char >= CH_0 && in_char <= CH_9) cls.kind = K_DIGIT;
		else if (in_char == CH_POINT)            cls.kind = K_POINT;
		else if (in_char == CH_PLUS)             cls.kind = K_PLUS;
		else if (in_char == CH_MINUS)            cls.kind = K_MINUS;
		else if (in_char == CH_TIMES)            cls.kind = K_TIMES;
		else if (in_char == CH_DIV)              cls.kind = K_DIV;
		else                                     cls.kind = K_OTHER;
	end

	assign in_ready  = (cnt_q != (PW+1)'(FIFO_D));
	assign push      = in_valid && in_ready;
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem_q[rd_q];

	// Store words in the queue
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (tok_pop) rd_q <= rd_q + 1'b1;
			if (push && !tok_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && tok_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/iee_mdu.sv
module iee_mdu
	import iee_pkg::*;
#(
	parameter int VALUE_WIDTH = 64,
	parameter int FRAC_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_mul,
	input  logic              start_div,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic              done,
	output logic [DATA_W-1:0] res,
	output logic              ovf
);

	localparam logic [DATA_W-1:0] VMAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_MUL  = 4'b0010,
		U_DIV  = 4'b0100,
		U_DONE = 4'b1000
	} ustate_t;

	ustate_t             st_q;
	logic                div_q;
	logic                neg_q;
	logic [DATA_W-1:0]   x_q;
	logic [DATA_W-1:0]   y_q;
	logic [6:0]          cnt_q;
	logic [63:0]         prod_q;
	logic [1:0]          ksel_q;
	logic [127:0]        acc_q;
	logic [127:0]        dvd_q;
	logic [DATA_W-1:0]   r_q;
	logic [DATA_W-1:0]   q_q;
	logic                qhi_q;
	logic [DATA_W-1:0]   ma;
	logic [DATA_W-1:0]   mb;
	logic [31:0]         xs;
	logic [31:0]         ys;
	logic [127:0]        pp;
	logic [DATA_W-1:0]   rs;
	logic                take;
	logic [127:0]        sh;
	sat_t                fin;

	assign ma = a[DATA_W-1] ? (~a + 1'b1) : a;
	assign mb = b[DATA_W-1] ? (~b + 1'b1) : b;

	// Pick the partial product for this step
	assign xs = cnt_q[1] ? x_q[63:32] : x_q[31:0];
	assign ys = cnt_q[0] ? y_q[63:32] : y_q[31:0];

	always_comb begin
		unique case (ksel_q)
			2'd0:    pp = {64'd0, prod_q};
			2'd3:    pp = {prod_q, 64'd0};
			default: pp = {32'd0, prod_q, 32'd0};
		endcase
	end

	// One restoring divide step
	assign rs   = {r_q[DATA_W-2:0], dvd_q[127]};
	assign take = r_q[DATA_W-1] || (rs >= y_q);

	assign sh   = acc_q >> FRAC_BITS;
	assign fin  = div_q ? pack_mag(neg_q, q_q, qhi_q, VMAX)
	                    : pack_mag(neg_q, sh[63:0], |sh[127:64], VMAX);
	assign done = (st_q == U_DONE);
	assign res  = fin.val;
	assign ovf  = fin.ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= U_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				U_IDLE: begin
					cnt_q <= '0;
					if (start_mul) st_q <= U_MUL;
					else if (start_div) st_q <= U_DIV;
				end
				U_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'd4) st_q <= U_DONE;
				end
				U_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'd127) st_q <= U_DONE;
				end
				U_DONE: st_q <= U_IDLE;
				default: st_q <= U_IDLE;
			endcase
		end
	end

	// Datapath: load operands, multiply in four partial products, divide bit by bit
	always_ff @(posedge clk) begin
		if (st_q == U_IDLE && (start_mul || start_div)) begin
			div_q <= start_div;
			neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
			x_q   <= ma;
			y_q   <= mb;
			acc_q <= '0;
			dvd_q <= {64'd0, ma} << FRAC_BITS;
			r_q   <= '0;
			q_q   <= '0;
			qhi_q <= 1'b0;
		end else if (st_q == U_MUL) begin
			if (cnt_q[6:2] == '0) begin
				prod_q <= xs * ys;
				ksel_q <= cnt_q[1:0];
			end
			if (cnt_q != '0) acc_q <= acc_q + pp;
		end else if (st_q == U_DIV) begin
			dvd_q <= {dvd_q[126:0], 1'b0};
			r_q   <= take ? (rs - y_q) : rs;
			qhi_q <= qhi_q | q_q[DATA_W-1];
			q_q   <= {q_q[DATA_W-2:0], take};
		end
	end

endmodule

### src/iee_back.sv
module iee_back
	import iee_pkg::*;
#(
	parameter int VALUE_WIDTH = 64,
	parameter int FRAC_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  tok_t              tok,
	output logic              tok_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_value,
	output status_t           out_status
);

	localparam logic [DATA_W-1:0] VMAX     = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
	localparam logic [DATA_W-1:0] VMAX_D10 = VMAX / 64'd10;
	localparam wtab_t             WTAB     = weight_table(FRAC_BITS);
	localparam int                IW       = $clog2(WT_DEPTH);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_EXEC = 5'b00010,
		B_FIN  = 5'b00100,
		B_WAIT = 5'b01000,
		B_OUT  = 5'b10000
	} bstate_t;

	bstate_t           st_q;
	tok_t              tok_q;
	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] term_q;
	logic [DATA_W-1:0] num_q;
	logic [IW-1:0]     widx_q;
	logic              in_num_q;
	logic              in_frac_q;
	logic              have_q;
	op_t               pend_q;
	status_t           err_q;

	// Number building
	logic [DATA_W-1:0]          base_num;
	logic                       base_frac;
	logic [IW-1:0]              base_idx;
	logic [FRAC_BITS+3:0]       dw;
	logic [DATA_W:0]            sum65;
	logic [DATA_W-1:0]          num_nx;
	logic                       frac_nx;
	logic [IW-1:0]              idx_nx;
	logic                       dig_ovf;

	// Number end
	logic [DATA_W-1:0] fin_sum;
	logic [DATA_W-1:0] fin_term;
	logic              fin_have;
	status_t           fin_code;
	logic              start_mul;
	logic              start_div;
	sat_t              add_r;
	sat_t              out_r;
	logic              is_num_tok;
	logic              do_fin;
	logic              out_free;
	status_t           flag_code;
	op_t               tok_op;

	logic              u_done;
	logic [DATA_W-1:0] u_res;
	logic              u_ovf;

	iee_mdu #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_mdu (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_mul (start_mul),
		.start_div (start_div),
		.a         (term_q),
		.b         (num_q),
		.done      (u_done),
		.res       (u_res),
		.ovf       (u_ovf)
	);

	assign tok_pop    = (st_q == B_IDLE) && tok_valid;
	assign is_num_tok = (tok_q.kind == K_DIGIT) || (tok_q.kind == K_POINT);
	assign out_free   = !out_valid || out_ready;

	// Build the number from one digit or point
	always_comb begin
		base_num  = in_num_q ? num_q : '0;
		base_frac = in_num_q && in_frac_q;
		base_idx  = in_num_q ? widx_q : '0;
		dw        = tok_q.digit * WTAB[base_idx][FRAC_BITS-1:0];
		num_nx    = base_num;
		frac_nx   = base_frac;
		idx_nx    = base_idx;
		dig_ovf   = 1'b0;
		sum65     = '0;
		if (tok_q.kind == K_POINT) begin
			frac_nx = 1'b1;
			if (!base_frac) idx_nx = '0;
		end else if (base_frac) begin
			sum65 = {1'b0, base_num} + (DATA_W+1)'(dw);
			if (sum65 > {1'b0, VMAX}) begin
				num_nx  = VMAX;
				dig_ovf = 1'b1;
			end else begin
				num_nx = sum65[DATA_W-1:0];
			end
			if (base_idx != IW'(WT_DEPTH - 1)) idx_nx = base_idx + 1'b1;
		end else if (base_num > VMAX_D10) begin
			num_nx  = VMAX;
			dig_ovf = 1'b1;
		end else begin
			sum65 = ({1'b0, base_num} << 3) + ({1'b0, base_num} << 1)
			      + ((DATA_W+1)'(tok_q.digit) << FRAC_BITS);
			if (sum65 > {1'b0, VMAX}) begin
				num_nx  = VMAX;
				dig_ovf = 1'b1;
			end else begin
				num_nx = sum65[DATA_W-1:0];
			end
		end
	end

	// Apply the pending operator to a finished number
	assign do_fin = ((st_q == B_EXEC) && !is_num_tok && in_num_q) || (st_q == B_FIN);
	assign add_r  = sat_add(sum_q, term_q, VMAX);

	always_comb begin
		fin_sum   = sum_q;
		fin_term  = term_q;
		fin_have  = have_q;
		fin_code  = ST_OK;
		start_mul = 1'b0;
		start_div = 1'b0;
		unique case (pend_q)
			OP_PLUS, OP_MINUS: begin
				if (have_q) begin
					fin_sum = add_r.val;
					if (add_r.ovf) fin_code = ST_OVF;
				end
				fin_term = (pend_q == OP_MINUS) ? (~num_q + 1'b1) : num_q;
				fin_have = 1'b1;
			end
			OP_TIMES: begin
				if (!have_q) fin_code = ST_NOTRM;
				else start_mul = do_fin;
			end
			OP_DIV: begin
				if (!have_q) begin
					fin_code = ST_NOTRM;
				end else if (num_q == '0) begin
					fin_code = ST_DIV0;
					if (term_q != '0) fin_term = term_q[DATA_W-1] ? (~VMAX) : VMAX;
				end else begin
					start_div = do_fin;
				end
			end
			default: ;
		endcase
	end

	// Operator taken from the current character
	always_comb begin
		unique case (tok_q.kind)
			K_PLUS:  tok_op = OP_PLUS;
			K_MINUS: tok_op = OP_MINUS;
			K_TIMES: tok_op = OP_TIMES;
			K_DIV:   tok_op = OP_DIV;
			default: tok_op = OP_NONE;
		endcase
	end

	assign out_r = have_q ? add_r : '{val: sum_q, ovf: 1'b0};

	// Error raised this cycle, if any
	always_comb begin
		flag_code = ST_OK;
		if (st_q == B_EXEC && is_num_tok && dig_ovf) flag_code = ST_OVF;
		else if (do_fin) flag_code = fin_code;
		else if (st_q == B_WAIT && u_done && u_ovf) flag_code = ST_OVF;
	end

	always_ff @(posedge clk) begin
		if (tok_pop) tok_q <= tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			sum_q      <= '0;
			term_q     <= '0;
			num_q      <= '0;
			widx_q     <= '0;
			in_num_q   <= 1'b0;
			in_frac_q  <= 1'b0;
			have_q     <= 1'b0;
			pend_q     <= OP_PLUS;
			err_q      <= ST_OK;
			out_valid  <= 1'b0;
			out_value  <= '0;
			out_status <= ST_OK;
		end else begin
			// Drop valid once taken, unless a new word replaces it
			if (out_valid && out_ready && st_q != B_OUT) out_valid <= 1'b0;
			if (flag_code != ST_OK && err_q == ST_OK) err_q <= flag_code;
			if (do_fin) begin
				in_num_q  <= 1'b0;
				in_frac_q <= 1'b0;
				sum_q     <= fin_sum;
				term_q    <= fin_term;
				have_q    <= fin_have;
			end
			unique case (st_q)
				B_IDLE: if (tok_valid) st_q <= B_EXEC;
				B_EXEC: begin
					if (is_num_tok) begin
						in_num_q  <= 1'b1;
						num_q     <= num_nx;
						in_frac_q <= frac_nx;
						widx_q    <= idx_nx;
						st_q      <= tok_q.last ? B_FIN : B_IDLE;
					end else begin
						pend_q <= tok_op;
						if (start_mul || start_div) st_q <= B_WAIT;
						else st_q <= tok_q.last ? B_OUT : B_IDLE;
					end
				end
				B_FIN: st_q <= (start_mul || start_div) ? B_WAIT : B_OUT;
				B_WAIT: begin
					if (u_done) begin
						term_q <= u_res;
						st_q   <= tok_q.last ? B_OUT : B_IDLE;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						out_value  <= out_r.val;
						out_status <= (err_q != ST_OK) ? err_q
						            : (out_r.ovf ? ST_OVF : ST_OK);
						sum_q      <= '0;
						term_q     <= '0;
						num_q      <= '0;
						widx_q     <= '0;
						in_num_q   <= 1'b0;
						in_frac_q  <= 1'b0;
						have_q     <= 1'b0;
						pend_q     <= OP_PLUS;
						err_q      <= ST_OK;
						st_q       <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

### src/infix_expression_evaluator.sv
// Infix expression evaluator, signed fixed point with FRAC_BITS fraction bits.
// Input stream: one character per word on s_axis; s_axis_tlast marks the
// last character of an expression. Output stream: one word per expression,
// sent after its last character, holding the saturated value and a status
// (ok, divide by zero, overflow, operator without a term).
// Throughput: a four-word queue decouples input from execution, so up to
// four characters are taken at one per cycle. The executor takes a new
// character only after it is through with the last one; a number ended
// by a pending * also waits for the four-step partial-product multiply,
// and a pending / for the bit-serial divider, which sets the worst case.
// Reset clears the queue, the evaluator state (empty sum, pending plus) and
// the output register. When the receiver stalls, the result is held in the
// output register; the executor then waits at the next result and the
// queue fills, after which s_axis_tready falls.
module infix_expression_evaluator
	import iee_pkg::*;
#(
	parameter int VALUE_WIDTH = 64,
	parameter int FRAC_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata    // [63:0] value, [65:64] status, [71:66] zero
);

	logic              tok_valid;
	tok_t              tok;
	logic              tok_pop;
	logic [DATA_W-1:0] out_value;
	status_t           out_status;

	iee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_char   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop)
	);

	iee_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (tok_valid),
		.tok        (tok),
		.tok_pop    (tok_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (out_value),
		.out_status (out_status)
	);

	assign m_axis_tdata = {6'd0, out_status, out_value};

	// Never pop an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |-> tok_valid)
		else $error("pop from empty queue");

	// Result stays within the configured signed range
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((&m_axis_tdata[63:VALUE_WIDTH-1]) ||
		                   !(|m_axis_tdata[63:VALUE_WIDTH-1])))
		else $error("result outside value range");

	// Never two pops in consecutive cycles
	a_pop_needs_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |=> !tok_pop)
		else $error("two pops in consecutive cycles");

endmodule
